/* hdl/mbfe_pkg.sv */
// Shared types, constants and codes for the marker bounded frame extractor.
package mbfe_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int MARKER_W       = 8;
    localparam int LEN_W          = 12;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int MARKER_RUN     = 3;
    localparam int FRAME_EXTRA    = 6;

    localparam logic [MARKER_W-1:0] MARKER_RESET = 8'd57;
    localparam logic [LEN_W-1:0]    LENGTH_RESET = 12'd2820;

    localparam logic REG_MARKER = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_GIVEN   = 2'd2;
    localparam logic [1:0] ST_NOFRAME = 2'd3;

    typedef struct packed {
        logic [MARKER_W-1:0] marker_value;
        logic [LEN_W-1:0]    payload_length;
    } cfg_t;

endpackage

/* hdl/marker_bounded_frame_extractor.sv */
// Top level: sequencer that stores, drains and searches framed bytes in a ring store.
//
// Input beats carry an action and a data byte. A push stores the byte in the ring
// (status 0) or drops it when the ring is full (status 1). A pull returns the next
// payload byte of a verified frame (status 2, last_of_frame on its final byte) or
// status 3 when no frame is ready. Every input beat gives exactly one result beat.
// After each beat the sequencer scans the ring one position at a time for three
// marker bytes, payload_length bytes and three more marker bytes. One shared
// wrapping address adder and the single ring read port serve every probe: each of
// the six marker bytes is read in S_READ and compared in S_COMP, and a position
// is given up at its first mismatch. A push, or a pull with no byte to give, goes
// from S_IDLE to S_CHECK; a pull that gives a byte passes S_PULL on the way. Each
// result moves from the result register into the output register. The
// next beat is taken once the scan ends and the previous result has moved into the
// output register.
// Reset empties the ring, clears all counters and loads marker 57 and length 2820;
// ring contents stay undefined. A stalled result is held in the output register and
// the following result waits behind it; input is stalled while the scan runs.
module marker_bounded_frame_extractor #(
    parameter int RING_DEPTH = mbfe_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          action,
    input  logic [7:0]                    data_byte,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [1:0]                    status,
    output logic [7:0]                    payload_byte,
    output logic                          last_of_frame,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbfe_pkg::PADDR_W-1:0]  paddr,
    input  logic [mbfe_pkg::PDATA_W-1:0]  pwdata,
    output logic [mbfe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int OFFW = mbfe_pkg::LEN_W + 1;
    localparam int SUMW = ((AW > OFFW) ? AW : OFFW) + 1;
    localparam int CMPW = (CW > OFFW) ? CW : OFFW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PULL  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_COMP  = 3'd4;

    localparam logic [2:0] PROBE_RUN  = 3'(mbfe_pkg::MARKER_RUN);
    localparam logic [2:0] PROBE_LAST = 3'(2 * mbfe_pkg::MARKER_RUN - 1);

    mbfe_pkg::cfg_t cfg;

    logic [2:0]                 state_reg;
    logic [2:0]                 probe_reg;
    logic [AW-1:0]              write_pos_reg;
    logic [AW-1:0]              search_pos_reg;
    logic [CW-1:0]              unread_reg;
    logic                       frame_ready_reg;
    logic [mbfe_pkg::LEN_W-1:0] drain_left_reg;

    logic       res_valid_reg;
    logic [1:0] res_status_reg;
    logic [7:0] res_byte_reg;
    logic       res_last_reg;
    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic [mbfe_pkg::LEN_W-1:0] eff_len;
    logic [OFFW-1:0]            need_len;
    logic                       search_go;
    logic [OFFW-1:0]            probe_off;
    logic [OFFW-1:0]            adder_off;
    logic [SUMW-1:0]            adder_sum;
    logic [AW-1:0]              adder_pos;
    logic [AW-1:0]              write_pos_next;
    logic [AW-1:0]              rd_addr;
    logic [7:0]                 rd_data;
    logic                       ring_we;
    logic                       item_take;
    logic                       ring_full;
    logic                       pull_ok;
    logic                       byte_match;
    logic                       out_take;

    mbfe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbfe_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (write_pos_reg),
        .wr_data (data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign item_stall = (state_reg != S_IDLE) || res_valid_reg;
    assign item_take  = item_valid && !item_stall;
    assign ring_full  = (unread_reg == CW'(RING_DEPTH));
    assign pull_ok    = frame_ready_reg && (drain_left_reg != '0) && (unread_reg != '0);
    assign ring_we    = item_take && !action && !ring_full;
    assign byte_match = (rd_data == cfg.marker_value);

    assign eff_len   = (cfg.payload_length == '0) ? mbfe_pkg::LEN_W'(1) : cfg.payload_length;
    assign need_len  = {1'b0, eff_len} + OFFW'(mbfe_pkg::FRAME_EXTRA);
    assign search_go = !frame_ready_reg && (CMPW'(unread_reg) >= CMPW'(need_len));

    // Header probes sit at offsets 0..2, trailer probes at length+3..length+5.
    assign probe_off = (probe_reg < PROBE_RUN) ? OFFW'(probe_reg)
                                               : ({1'b0, eff_len} + OFFW'(probe_reg));

    always_comb
    begin
        if (state_reg == S_COMP)
        begin
            adder_off = (byte_match && (probe_reg == PROBE_LAST))
                      ? OFFW'(mbfe_pkg::MARKER_RUN) : OFFW'(1);
        end
        else
        begin
            adder_off = probe_off;
        end
        adder_sum = SUMW'(search_pos_reg) + SUMW'(adder_off);
        if (adder_sum >= SUMW'(RING_DEPTH))
        begin
            adder_sum = adder_sum - SUMW'(RING_DEPTH);
        end
        adder_pos = adder_sum[AW-1:0];
    end

    assign write_pos_next = (write_pos_reg == AW'(RING_DEPTH - 1)) ? '0
                                                                   : write_pos_reg + AW'(1);
    assign rd_addr = (state_reg == S_READ) ? adder_pos : search_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            probe_reg       <= '0;
            write_pos_reg   <= '0;
            search_pos_reg  <= '0;
            unread_reg      <= '0;
            frame_ready_reg <= 1'b0;
            drain_left_reg  <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_take)
                    begin
                        res_byte_reg <= 8'd0;
                        res_last_reg <= 1'b0;
                        if (!action)
                        begin
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_CHECK;
                            if (ring_full)
                            begin
                                res_status_reg <= mbfe_pkg::ST_DROPPED;
                            end
                            else
                            begin
                                res_status_reg <= mbfe_pkg::ST_STORED;
                                write_pos_reg  <= write_pos_next;
                                unread_reg     <= unread_reg + CW'(1);
                            end
                        end
                        else if (pull_ok)
                        begin
                            res_status_reg <= mbfe_pkg::ST_GIVEN;
                            res_last_reg   <= (drain_left_reg == mbfe_pkg::LEN_W'(1));
                            search_pos_reg <= (search_pos_reg == AW'(RING_DEPTH - 1))
                                            ? '0 : search_pos_reg + AW'(1);
                            unread_reg     <= unread_reg - CW'(1);
                            drain_left_reg <= drain_left_reg - mbfe_pkg::LEN_W'(1);
                            if (drain_left_reg == mbfe_pkg::LEN_W'(1))
                            begin
                                frame_ready_reg <= 1'b0;
                            end
                            state_reg <= S_PULL;
                        end
                        else
                        begin
                            res_status_reg <= mbfe_pkg::ST_NOFRAME;
                            res_valid_reg  <= 1'b1;
                            state_reg      <= S_CHECK;
                        end
                    end
                end
                S_PULL:
                begin
                    res_byte_reg  <= rd_data;
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_CHECK;
                end
                S_CHECK:
                begin
                    probe_reg <= '0;
                    state_reg <= search_go ? S_READ : S_IDLE;
                end
                S_READ:
                begin
                    state_reg <= S_COMP;
                end
                S_COMP:
                begin
                    if (!byte_match)
                    begin
                        search_pos_reg <= adder_pos;
                        unread_reg     <= unread_reg - CW'(1);
                        state_reg      <= S_CHECK;
                    end
                    else if (probe_reg == PROBE_LAST)
                    begin
                        search_pos_reg  <= adder_pos;
                        unread_reg      <= unread_reg - CW'(mbfe_pkg::MARKER_RUN);
                        frame_ready_reg <= 1'b1;
                        drain_left_reg  <= eff_len;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        probe_reg <= probe_reg + 3'd1;
                        state_reg <= S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_take = res_valid_reg && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_status_reg <= res_status_reg;
            out_byte_reg   <= res_byte_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign status        = out_status_reg;
    assign payload_byte  = out_byte_reg;
    assign last_of_frame = out_last_reg;

`ifndef ASSERT_OFF
    a_unread_bound: assert property (@(posedge clk) disable iff (!rst_n)
        unread_reg <= CW'(RING_DEPTH))
        else $error("unread count exceeds ring depth");

    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready_reg |-> (drain_left_reg != '0))
        else $error("frame ready with nothing left to drain");

    a_drain_stored: assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready_reg |-> (CMPW'(unread_reg) >= CMPW'(drain_left_reg)))
        else $error("pending payload larger than stored bytes");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> (state_reg != S_IDLE))
        else $error("accepted beat did not start the sequencer");

    a_last_given: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_frame) |-> (status == mbfe_pkg::ST_GIVEN))
        else $error("last flag on a result that gives no payload byte");
`endif

endmodule

/* hdl/mbfe_ring.sv */
// Ring store: one write port and one read port with registered read data.
module mbfe_ring #(
    parameter int DEPTH = mbfe_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] store_reg [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/mbfe_cfg.sv */
// APB register bank holding the marker value and the payload length.
module mbfe_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbfe_pkg::PADDR_W-1:0]  paddr,
    input  logic [mbfe_pkg::PDATA_W-1:0]  pwdata,
    output logic [mbfe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output mbfe_pkg::cfg_t                cfg
);

    logic [mbfe_pkg::MARKER_W-1:0] marker_reg;
    logic [mbfe_pkg::LEN_W-1:0]    length_reg;
    logic                          wr_en;
    logic                          reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= mbfe_pkg::MARKER_RESET;
            length_reg <= mbfe_pkg::LENGTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                mbfe_pkg::REG_MARKER: marker_reg <= pwdata[mbfe_pkg::MARKER_W-1:0];
                mbfe_pkg::REG_LENGTH: length_reg <= pwdata[mbfe_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            mbfe_pkg::REG_MARKER:
                prdata = {{(mbfe_pkg::PDATA_W-mbfe_pkg::MARKER_W){1'b0}}, marker_reg};
            mbfe_pkg::REG_LENGTH:
                prdata = {{(mbfe_pkg::PDATA_W-mbfe_pkg::LEN_W){1'b0}}, length_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.marker_value   = marker_reg;
    assign cfg.payload_length = length_reg;

endmodule
